// ===== rtl/core/swept_circle_hit_test_wrapped_assert.svh =====
// ----------------------------------------------------------------------------
// Swept circle hit test assertion macros
// Shared property forms for the block checkers.
// ----------------------------------------------------------------------------
`ifndef SWEPT_CIRCLE_HIT_TEST_WRAPPED_ASSERT_SVH
`define SWEPT_CIRCLE_HIT_TEST_WRAPPED_ASSERT_SVH

// same-cycle implication, off during reset
`define SCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define SCH_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle hit test package
// Shared constants, register indexes and types.
// ----------------------------------------------------------------------------
package sch_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 10;
    localparam int REG_BITS        = 15;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [REG_BITS-1:0] FIELD_WIDTH_RST  = 15'd1024;
    localparam logic [REG_BITS-1:0] FIELD_HEIGHT_RST = 15'd1024;

    // magnitude width of a folded axis distance
    function automatic int dist_bits(input int coord_bits);
        return (coord_bits + 1 > REG_BITS) ? coord_bits + 1 : REG_BITS;
    endfunction

    // stage enables for one axis distance unit
    typedef struct packed {
        logic en_abs;
        logic en_fold;
        logic en_sq;
    } t_axis_en;

endpackage

// ===== rtl/core/swept_circle_hit_test_wrapped.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle hit test, wrapped field
// Flags a point within the kill radius of a moving segment on a torus.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     i_valid / o_stall         i_point_*, i_start_*, i_end_*, i_radius
//  result    o_valid / i_stall         o_is_hit
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Nine register stages; one transaction is taken every cycle while o_stall
//  is low.
//  Stages: axis abs, fold, square, sums, cross term, partial products,
//  product sums, difference, compare into the output register.
//  Each stage moves when it is empty or the one after it moves, so bubbles
//  close up; o_stall rises only with all stages full and the output stalled.
//  Reset is synchronous; it clears all valid bits and sets both periods to
//  1024.
// ----------------------------------------------------------------------------
module swept_circle_hit_test_wrapped
    import sch_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    input  logic        [RADIUS_BITS-1:0] i_radius,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_hit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [REG_BITS-1:0]           i_cfg_data
);

    localparam int NUM_STAGES = 9;
    localparam int D_BITS = dist_bits(COORD_BITS);
    localparam int AX_W   = 2*D_BITS;
    localparam int SQ_W   = AX_W + 1;
    localparam int DW     = SQ_W + 2;
    localparam int RR_W   = 2*RADIUS_BITS;
    localparam int AL     = (SQ_W + 1) / 2;
    localparam int AH     = SQ_W - AL;
    localparam int DL     = (SQ_W + 2) / 2;
    localparam int DH     = SQ_W + 1 - DL;
    localparam int PW_A   = 2*SQ_W + 2;
    localparam int PW_K   = RR_W + SQ_W + 2;
    localparam int PW     = (PW_A > PW_K) ? PW_A : PW_K;

    logic [REG_BITS-1:0]   r_field_width;
    logic [REG_BITS-1:0]   r_field_height;

    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES:1]   w_adv;
    t_axis_en              w_axis_en;

    logic [AX_W-1:0]       w_sq_psx, w_sq_psy, w_sq_sex, w_sq_sey, w_sq_epx, w_sq_epy;

    logic [RADIUS_BITS-1:0] r_rad1;
    logic [RR_W-1:0]        r_rr2, r_rr3, r_rr4, r_rr5;

    logic [SQ_W-1:0]       r_a2_4, r_b2_4, r_c2_4;
    logic [SQ_W-1:0]       r_a2_5, r_b2_5;
    logic signed [DW-1:0]  r_d5;
    logic                  r_coinc5, r_b2nz5;

    logic                  w_dpos, w_dlt;
    logic [SQ_W:0]         w_dm;
    logic [AL+SQ_W-1:0]    r_pal6;
    logic [AH+SQ_W-1:0]    r_pah6;
    logic [DL+SQ_W:0]      r_pdl6;
    logic [DH+SQ_W:0]      r_pdh6;
    logic [RR_W+SQ_W-1:0]  r_prk6;
    logic                  r_coinc6, r_chk6;

    logic [PW-1:0]         r_p7, r_q7, r_k7;
    logic                  r_coinc7, r_chk7;

    logic [PW:0]           w_diff;
    logic [PW-1:0]         r_diff8, r_k8;
    logic                  r_coinc8, r_chk8;

    logic                  r_hit9;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= FIELD_WIDTH_RST;
            r_field_height <= FIELD_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_field_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_field_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain
    always_comb begin
        w_adv[NUM_STAGES] = !r_vld[NUM_STAGES] || !i_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_axis_en = '{en_abs: w_adv[1], en_fold: w_adv[2], en_sq: w_adv[3]};

    // stages 1 to 3: folded squared distances per axis
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_psx (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_point_x), .i_v(i_start_x),
        .i_period(r_field_width), .o_sq(w_sq_psx)
    );
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_psy (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_point_y), .i_v(i_start_y),
        .i_period(r_field_height), .o_sq(w_sq_psy)
    );
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_sex (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_start_x), .i_v(i_end_x),
        .i_period(r_field_width), .o_sq(w_sq_sex)
    );
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_sey (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_start_y), .i_v(i_end_y),
        .i_period(r_field_height), .o_sq(w_sq_sey)
    );
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_epx (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_end_x), .i_v(i_point_x),
        .i_period(r_field_width), .o_sq(w_sq_epx)
    );
    sch_axis_sq #(.COORD_BITS(COORD_BITS)) u_epy (
        .i_clk(i_clk), .i_en(w_axis_en), .i_u(i_end_y), .i_v(i_point_y),
        .i_period(r_field_height), .o_sq(w_sq_epy)
    );

    // radius squared rides alongside
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_rad1 <= i_radius;
        end
        if (w_adv[2]) begin
            r_rr2 <= RR_W'(r_rad1) * RR_W'(r_rad1);
        end
        if (w_adv[3]) begin
            r_rr3 <= r_rr2;
        end
        if (w_adv[4]) begin
            r_rr4 <= r_rr3;
        end
        if (w_adv[5]) begin
            r_rr5 <= r_rr4;
        end
    end

    // stage 4: side lengths squared
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_a2_4 <= SQ_W'(w_sq_psx) + SQ_W'(w_sq_psy);
            r_b2_4 <= SQ_W'(w_sq_sex) + SQ_W'(w_sq_sey);
            r_c2_4 <= SQ_W'(w_sq_epx) + SQ_W'(w_sq_epy);
        end
    end

    // stage 5: d = a2 + b2 - c2
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_d5     <= $signed(DW'(r_a2_4)) + $signed(DW'(r_b2_4)) - $signed(DW'(r_c2_4));
            r_a2_5   <= r_a2_4;
            r_b2_5   <= r_b2_4;
            r_coinc5 <= (r_a2_4 == '0) || (r_c2_4 == '0);
            r_b2nz5  <= (r_b2_4 != '0);
        end
    end

    // stage 6: range check and partial products
    always_comb begin
        w_dpos = !r_d5[DW-1] && (r_d5 != '0);
        w_dlt  = r_d5 < $signed({1'b0, r_b2_5, 1'b0});
        w_dm   = r_d5[SQ_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_pal6   <= (AL+SQ_W)'(r_a2_5[AL-1:0]) * (AL+SQ_W)'(r_b2_5);
            r_pah6   <= (AH+SQ_W)'(r_a2_5[SQ_W-1:AL]) * (AH+SQ_W)'(r_b2_5);
            r_pdl6   <= (DL+SQ_W+1)'(w_dm[DL-1:0]) * (DL+SQ_W+1)'(w_dm);
            r_pdh6   <= (DH+SQ_W+1)'(w_dm[SQ_W:DL]) * (DH+SQ_W+1)'(w_dm);
            r_prk6   <= (RR_W+SQ_W)'(r_rr5) * (RR_W+SQ_W)'(r_b2_5);
            r_coinc6 <= r_coinc5;
            r_chk6   <= r_b2nz5 && w_dpos && w_dlt;
        end
    end

    // stage 7: 4*a2*b2, d*d, 4*r*r*b2
    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_p7     <= (PW'(r_pah6) << (AL + 2)) + (PW'(r_pal6) << 2);
            r_q7     <= (PW'(r_pdh6) << DL) + PW'(r_pdl6);
            r_k7     <= PW'(r_prk6) << 2;
            r_coinc7 <= r_coinc6;
            r_chk7   <= r_chk6;
        end
    end

    // stage 8: 4*a2*b2 - d*d
    assign w_diff = {1'b0, r_p7} - {1'b0, r_q7};

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r_diff8  <= w_diff[PW-1:0];
            r_k8     <= r_k7;
            r_coinc8 <= r_coinc7;
            r_chk8   <= r_chk7 && !w_diff[PW];
        end
    end

    // stage 9: output register
    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            r_hit9 <= r_coinc8 || (r_chk8 && (r_diff8 < r_k8));
        end
    end

    assign o_valid  = r_vld[NUM_STAGES];
    assign o_is_hit = r_hit9;

endmodule

// ===== rtl/core/sch_axis_sq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle hit test axis distance
// Three-stage wrapped distance squared along one axis.
// ----------------------------------------------------------------------------
module sch_axis_sq
    import sch_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  t_axis_en                               i_en,
    input  logic signed [COORD_BITS-1:0]           i_u,
    input  logic signed [COORD_BITS-1:0]           i_v,
    input  logic        [REG_BITS-1:0]             i_period,
    output logic        [2*dist_bits(COORD_BITS)-1:0] o_sq
);

    localparam int D_BITS = dist_bits(COORD_BITS);

    logic signed [COORD_BITS:0] w_diff;
    logic        [COORD_BITS:0] n_abs;
    logic        [COORD_BITS:0] r_abs;
    logic        [D_BITS-1:0]   w_abs_ext;
    logic        [D_BITS-1:0]   w_per_ext;
    logic        [D_BITS-1:0]   w_half;
    logic signed [D_BITS:0]     w_fold;
    logic        [D_BITS-1:0]   n_fold;
    logic        [D_BITS-1:0]   r_fold;
    logic        [2*D_BITS-1:0] r_sq;

    always_comb begin
        w_diff = (COORD_BITS+1)'(i_u) - (COORD_BITS+1)'(i_v);
        n_abs  = w_diff[COORD_BITS] ? (COORD_BITS+1)'(-w_diff) : (COORD_BITS+1)'(w_diff);
    end

    always_comb begin
        w_abs_ext = D_BITS'(r_abs);
        w_per_ext = D_BITS'(i_period);
        w_half    = D_BITS'(i_period >> 1);
        w_fold    = $signed({1'b0, w_per_ext}) - $signed({1'b0, w_abs_ext});
        if (w_abs_ext > w_half) begin
            n_fold = w_fold[D_BITS] ? D_BITS'(-w_fold) : D_BITS'(w_fold);
        end else begin
            n_fold = w_abs_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_abs) begin
            r_abs <= n_abs;
        end
        if (i_en.en_fold) begin
            r_fold <= n_fold;
        end
        if (i_en.en_sq) begin
            r_sq <= (2*D_BITS)'(r_fold) * (2*D_BITS)'(r_fold);
        end
    end

    assign o_sq = r_sq;

endmodule

// ===== rtl/core/sch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle hit test checker
// Port-level checks on handshake timing and the coincident-endpoint path.
// ----------------------------------------------------------------------------
`include "swept_circle_hit_test_wrapped_assert.svh"

module sch_checker
    import sch_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic signed [COORD_BITS-1:0]  i_point_x,
    input logic signed [COORD_BITS-1:0]  i_point_y,
    input logic signed [COORD_BITS-1:0]  i_start_x,
    input logic signed [COORD_BITS-1:0]  i_start_y,
    input logic signed [COORD_BITS-1:0]  i_end_x,
    input logic signed [COORD_BITS-1:0]  i_end_y,
    input logic        [RADIUS_BITS-1:0] i_radius,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_is_hit,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input logic [REG_BITS-1:0]           i_cfg_data
);

    localparam int FLOW_LEN = 8;

    logic                w_flow;
    logic                w_coinc_acc;
    logic [FLOW_LEN-1:0] r_flow;

    assign w_flow      = i_rst_n && !i_stall;
    assign w_coinc_acc = i_rst_n && i_valid && !o_stall
                         && (i_point_x == i_start_x) && (i_point_y == i_start_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= '0;
        end else begin
            r_flow <= {r_flow[FLOW_LEN-2:0], w_flow};
        end
    end

    `SCH_ASSERT_RST(a_rst_clears_out, i_clk, !i_rst_n, !o_valid, "output valid after reset")
    `SCH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_is_hit), "stalled result changed")
    `SCH_ASSERT_IMP(a_stall_backpressure, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while output free")
    `SCH_ASSERT_IMP(a_coinc_hit, i_clk, i_rst_n, $past(w_coinc_acc, 9) && (r_flow == '1), o_valid && o_is_hit, "coincident point missed")

endmodule

bind swept_circle_hit_test_wrapped sch_checker #(
    .COORD_BITS(COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
) u_sch_checker (.*);
